/* hw/rtl/crg_pkg.sv */
// Shared types, codes and constants for the CEREG reply scanner and grace window.
`default_nettype none
package crg_pkg;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic RK_VERDICT = 1'b0;
  localparam logic RK_QUERY   = 1'b1;

  localparam logic [2:0] PREFIX_LEN = 3'd7;
  localparam logic [6:0] MODE_MAX   = 7'd5;
  localparam logic [6:0] STATUS_MAX = 7'd10;
  localparam logic [3:0] STAT_HOME  = 4'd1;
  localparam logic [3:0] STAT_ROAM  = 4'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] GRACE_RESET = 32'd300;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_START,
    PH_PREFIX,
    PH_OTHER,
    PH_MODE_WS,
    PH_MODE_DIG,
    PH_MODE_TRAIL,
    PH_STAT_WS,
    PH_STAT_DIG,
    PH_STAT_TRAIL,
    PH_GOOD,
    PH_BAD,
    PH_TERM
  } phase_t;

  typedef enum logic [1:0] {
    EV_VERDICT,
    EV_CLEAR,
    EV_QUERY
  } ev_kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        reply_ok;
    logic [31:0] now_s;
  } crg_in_t;

  typedef struct packed {
    logic result_kind;
    logic parse_ok;
    logic is_registered;
    logic grace_started;
    logic grace_active;
  } crg_out_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic        good;
    logic        reg_status;
    logic [31:0] now_s;
  } ev_t;

  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h2b;
      3'd1: c = 8'h43;
      3'd2: c = 8'h45;
      3'd3: c = 8'h52;
      3'd4: c = 8'h45;
      3'd5: c = 8'h47;
      3'd6: c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/crg_front.sv */
// Front end: accepts transactions, scans reply bytes and classifies them into events.
`default_nettype none
module crg_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire crg_pkg::crg_in_t req_data,
  input  wire logic             queue_full,
  output logic                  req_stall,
  output logic                  ev_push,
  output crg_pkg::ev_t          ev_data
);

  crg_pkg::phase_t phase, phase_next;
  logic [2:0] pidx, pidx_next;
  logic [3:0] acc, acc_next;
  logic [3:0] pend, pend_next;
  logic [3:0] comm, comm_next;
  logic [1:0] seen, seen_next;
  logic       fail, fail_next;

  logic       accept;
  logic [7:0] b;
  logic       blank;
  logic       digit;
  logic [3:0] dval;
  logic [6:0] sum;
  logic       tag_hit;
  logic       cereg_line;
  logic       good_line;
  logic [3:0] pend_line;
  logic       good_reply;

  assign req_stall = queue_full;
  assign accept    = req_valid && !req_stall;
  assign b         = req_data.data_byte;
  assign blank     = (b == crg_pkg::CH_SPACE) || (b == crg_pkg::CH_TAB);
  assign digit     = (b >= crg_pkg::CH_ZERO) && (b <= crg_pkg::CH_NINE);
  assign dval      = 4'(b - crg_pkg::CH_ZERO);
  assign sum       = 7'(acc) * 7'd10 + 7'(dval);
  assign tag_hit   = (pidx < crg_pkg::PREFIX_LEN) && (b == crg_pkg::tag_char(pidx));

  always_comb begin
    phase_next = phase;
    pidx_next  = pidx;
    acc_next   = acc;
    pend_next  = pend;
    comm_next  = comm;
    seen_next  = seen;
    fail_next  = fail;
    cereg_line = (phase >= crg_pkg::PH_MODE_WS) && (phase <= crg_pkg::PH_BAD);
    good_line  = (phase == crg_pkg::PH_STAT_DIG) || (phase == crg_pkg::PH_STAT_TRAIL) ||
                 (phase == crg_pkg::PH_GOOD);
    pend_line  = ((phase == crg_pkg::PH_STAT_DIG) || (phase == crg_pkg::PH_STAT_TRAIL)) ?
                 acc : pend;
    if (accept && (req_data.cmd == crg_pkg::CMD_BYTE)) begin
      if (phase == crg_pkg::PH_TERM) begin
        phase_next = phase;
      end else if (b == crg_pkg::CH_NUL) begin
        phase_next = crg_pkg::PH_TERM;
      end else if (b == crg_pkg::CH_LF) begin
        pend_next = pend_line;
        if (cereg_line) begin
          if ((seen != 2'd0) || !good_line) begin
            fail_next = 1'b1;
          end else begin
            comm_next = pend_line;
          end
          if (seen < 2'd2) begin
            seen_next = seen + 2'd1;
          end
        end
        phase_next = crg_pkg::PH_START;
        pidx_next  = 3'd0;
        acc_next   = 4'd0;
      end else begin
        case (phase)
          crg_pkg::PH_START, crg_pkg::PH_PREFIX: begin
            if ((phase == crg_pkg::PH_PREFIX) || !blank) begin
              if (tag_hit) begin
                if (pidx == crg_pkg::PREFIX_LEN - 3'd1) begin
                  phase_next = crg_pkg::PH_MODE_WS;
                  pidx_next  = 3'd0;
                  acc_next   = 4'd0;
                end else begin
                  phase_next = crg_pkg::PH_PREFIX;
                  pidx_next  = pidx + 3'd1;
                end
              end else begin
                phase_next = crg_pkg::PH_OTHER;
              end
            end
          end
          crg_pkg::PH_MODE_WS: begin
            if (!blank) begin
              acc_next = 4'd0;
              if (digit && (7'(dval) <= crg_pkg::MODE_MAX)) begin
                acc_next   = dval;
                phase_next = crg_pkg::PH_MODE_DIG;
              end else begin
                phase_next = crg_pkg::PH_BAD;
              end
            end
          end
          crg_pkg::PH_MODE_DIG: begin
            if (digit) begin
              if (sum <= crg_pkg::MODE_MAX) begin
                acc_next = sum[3:0];
              end else begin
                phase_next = crg_pkg::PH_BAD;
              end
            end else if (blank) begin
              phase_next = crg_pkg::PH_MODE_TRAIL;
            end else if (b == crg_pkg::CH_COMMA) begin
              phase_next = crg_pkg::PH_STAT_WS;
            end else begin
              phase_next = crg_pkg::PH_BAD;
            end
          end
          crg_pkg::PH_MODE_TRAIL: begin
            if (!blank) begin
              phase_next = (b == crg_pkg::CH_COMMA) ? crg_pkg::PH_STAT_WS : crg_pkg::PH_BAD;
            end
          end
          crg_pkg::PH_STAT_WS: begin
            if (!blank) begin
              acc_next = 4'd0;
              if (digit && (7'(dval) <= crg_pkg::STATUS_MAX)) begin
                acc_next   = dval;
                phase_next = crg_pkg::PH_STAT_DIG;
              end else begin
                phase_next = crg_pkg::PH_BAD;
              end
            end
          end
          crg_pkg::PH_STAT_DIG, crg_pkg::PH_STAT_TRAIL: begin
            if (digit && (phase == crg_pkg::PH_STAT_DIG)) begin
              if (sum <= crg_pkg::STATUS_MAX) begin
                acc_next = sum[3:0];
              end else begin
                phase_next = crg_pkg::PH_BAD;
              end
            end else if (blank) begin
              phase_next = crg_pkg::PH_STAT_TRAIL;
            end else if ((b == crg_pkg::CH_COMMA) || (b == crg_pkg::CH_CR)) begin
              pend_next  = acc;
              phase_next = crg_pkg::PH_GOOD;
            end else begin
              phase_next = crg_pkg::PH_BAD;
            end
          end
          crg_pkg::PH_GOOD, crg_pkg::PH_BAD, crg_pkg::PH_OTHER, crg_pkg::PH_TERM: begin
            phase_next = phase;
          end
          default: begin
            phase_next = crg_pkg::PH_OTHER;
          end
        endcase
      end
    end

    good_reply = req_data.reply_ok && !fail_next && (seen_next == 2'd1);

    ev_push       = 1'b0;
    ev_data.kind  = crg_pkg::EV_VERDICT;
    ev_data.good  = good_reply;
    ev_data.reg_status = (comm_next == crg_pkg::STAT_HOME) || (comm_next == crg_pkg::STAT_ROAM);
    ev_data.now_s = req_data.now_s;
    if (accept) begin
      case (req_data.cmd)
        crg_pkg::CMD_BYTE: begin
          if (req_data.last_byte) begin
            ev_push    = 1'b1;
            phase_next = crg_pkg::PH_START;
            pidx_next  = 3'd0;
            acc_next   = 4'd0;
            pend_next  = 4'd0;
            comm_next  = 4'd0;
            seen_next  = 2'd0;
            fail_next  = 1'b0;
          end
        end
        crg_pkg::CMD_CLEAR: begin
          ev_push      = 1'b1;
          ev_data.kind = crg_pkg::EV_CLEAR;
        end
        crg_pkg::CMD_QUERY: begin
          ev_push      = 1'b1;
          ev_data.kind = crg_pkg::EV_QUERY;
        end
        default: begin
          ev_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= crg_pkg::PH_START;
      pidx  <= 3'd0;
      acc   <= 4'd0;
      pend  <= 4'd0;
      comm  <= 4'd0;
      seen  <= 2'd0;
      fail  <= 1'b0;
    end else begin
      phase <= phase_next;
      pidx  <= pidx_next;
      acc   <= acc_next;
      pend  <= pend_next;
      comm  <= comm_next;
      seen  <= seen_next;
      fail  <= fail_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/crg_queue.sv */
// Short event queue between the front end and the back end.
`default_nettype none
module crg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire crg_pkg::ev_t  push_data,
  input  wire logic          pop,
  output logic               full,
  output logic               head_valid,
  output crg_pkg::ev_t       head_data
);

  crg_pkg::ev_t entries [crg_pkg::QUEUE_DEPTH];
  logic [crg_pkg::QPTR_W-1:0] wr_ptr;
  logic [crg_pkg::QPTR_W-1:0] rd_ptr;
  logic [crg_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full       = (count == crg_pkg::QCNT_W'(crg_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [crg_pkg::QPTR_W-1:0] bump(input logic [crg_pkg::QPTR_W-1:0] p);
    logic [crg_pkg::QPTR_W-1:0] n;
    if (p == crg_pkg::QPTR_W'(crg_pkg::QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + crg_pkg::QPTR_W'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + crg_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - crg_pkg::QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= crg_pkg::QCNT_W'(crg_pkg::QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  assert property (@(posedge clk) disable iff (rst)
    !push || !full)
    else $error("Event pushed into a full queue.");

  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + crg_pkg::QCNT_W'(1)))
    else $error("Queue count did not grow on a lone push.");

endmodule
`default_nettype wire

/* hw/rtl/crg_back.sv */
// Back end: registration flags, grace window and the registered result stage.
`default_nettype none
module crg_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ev_valid,
  input  wire crg_pkg::ev_t      ev_data,
  output logic                   ev_pop,
  input  wire logic              cfg_valid,
  input  wire logic [31:0]       cfg_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output crg_pkg::crg_out_t      rsp_data
);

  logic [31:0] grace_len;
  logic        reg_seen;
  logic        reg_now;
  logic        taken;
  logic [31:0] start_time;

  logic        back_to_reg;
  logic        start_now;
  logic        active;
  logic [31:0] elapsed;

  assign ev_pop      = ev_valid && (!rsp_valid || !rsp_stall);
  assign back_to_reg = reg_seen && !reg_now && ev_data.reg_status;
  assign start_now   = ev_data.good && back_to_reg && !taken;
  assign elapsed     = ev_data.now_s - start_time;
  assign active      = taken && (elapsed < grace_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      grace_len <= crg_pkg::GRACE_RESET;
    end else if (cfg_valid) begin
      grace_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_seen   <= 1'b0;
      reg_now    <= 1'b0;
      taken      <= 1'b0;
      start_time <= 32'd0;
      rsp_valid  <= 1'b0;
    end else begin
      if (ev_pop && ((ev_data.kind == crg_pkg::EV_VERDICT) ||
                     (ev_data.kind == crg_pkg::EV_QUERY))) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (ev_pop) begin
        case (ev_data.kind)
          crg_pkg::EV_VERDICT: begin
            if (ev_data.good) begin
              reg_seen <= 1'b1;
              reg_now  <= ev_data.reg_status;
            end
            if (start_now) begin
              taken      <= 1'b1;
              start_time <= ev_data.now_s;
            end
          end
          crg_pkg::EV_CLEAR: begin
            taken      <= 1'b0;
            start_time <= 32'd0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      case (ev_data.kind)
        crg_pkg::EV_VERDICT: begin
          rsp_data.result_kind   <= crg_pkg::RK_VERDICT;
          rsp_data.parse_ok      <= ev_data.good;
          rsp_data.is_registered <= ev_data.good && ev_data.reg_status;
          rsp_data.grace_started <= start_now;
          rsp_data.grace_active  <= 1'b0;
        end
        crg_pkg::EV_QUERY: begin
          rsp_data.result_kind   <= crg_pkg::RK_QUERY;
          rsp_data.parse_ok      <= 1'b0;
          rsp_data.is_registered <= 1'b0;
          rsp_data.grace_started <= 1'b0;
          rsp_data.grace_active  <= active;
        end
        default: begin
          rsp_data <= rsp_data;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (ev_pop && (ev_data.kind == crg_pkg::EV_VERDICT) && start_now) |=> taken)
    else $error("Grace window opened without being marked as taken.");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.result_kind == crg_pkg::RK_QUERY)) |->
      (!rsp_data.parse_ok && !rsp_data.is_registered && !rsp_data.grace_started))
    else $error("Query answer carries verdict fields.");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
    else $error("Stalled result changed or vanished.");

endmodule
`default_nettype wire

/* hw/rtl/cereg_reply_registration_grace.sv */
// A result passes through the event queue and then the registered result stage before it is valid.
// Throughput: one transaction per cycle while req_stall is low; the byte scanner updates once per byte.
// A two-entry event queue separates the byte scanner from the grace window logic.
// Reset clears the scanner, queue, flags and grace window; grace length returns to 300.
`default_nettype none
module cereg_reply_registration_grace (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire crg_pkg::crg_in_t  req_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output crg_pkg::crg_out_t      rsp_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [31:0]       cfg_data
);

  logic         queue_full;
  logic         ev_push;
  crg_pkg::ev_t ev_in;
  logic         ev_pop;
  logic         ev_valid;
  crg_pkg::ev_t ev_head;

  assign cfg_ready = 1'b1;

  crg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_data   (req_data),
    .queue_full (queue_full),
    .req_stall  (req_stall),
    .ev_push    (ev_push),
    .ev_data    (ev_in)
  );

  crg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (ev_push),
    .push_data  (ev_in),
    .pop        (ev_pop),
    .full       (queue_full),
    .head_valid (ev_valid),
    .head_data  (ev_head)
  );

  crg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev_data   (ev_head),
    .ev_pop    (ev_pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
`default_nettype wire
